### hw/rtl/amsa_pkg.sv
// Shared types, constants and helpers of the ADC mux scan averager.
`timescale 1ns / 1ps
`default_nettype none

package amsa_pkg;

   localparam int IN_W        = 16;  // raw conversion width
   localparam int ADC_W       = 12;  // valid conversion and reading width
   localparam int SUM_W       = 16;  // accumulator width
   localparam int CHAN_W      = 8;   // channel index width
   localparam int SEL_W       = 4;   // node and mux select width
   localparam int CNT_CFG_W   = 5;   // node_inputs / mux_count register width
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int QUEUE_DEPTH = 2;

   localparam int DEFAULT_SAMPLES      = 4;
   localparam int DEFAULT_MAX_CHANNELS = 256;

   localparam logic [CNT_CFG_W-1:0] SEL_COUNT_MAX     = 5'd16;
   localparam logic [CNT_CFG_W-1:0] NODE_INPUTS_RESET = 5'd16;
   localparam logic [CNT_CFG_W-1:0] MUX_COUNT_RESET   = 5'd2;
   localparam logic [ADC_W-1:0]     ADC_MAX_RESET     = 12'hFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_INPUTS = 2'd0,
      CSR_MUX_COUNT   = 2'd1,
      CSR_ADC_MAX     = 2'd2
   } csr_index_type;

   // Classified sample handed from the front to the back.
   typedef struct packed {
      logic             accepted;
      logic [ADC_W-1:0] value;
   } sample_type;

   // Scan setup seen by the back.
   typedef struct packed {
      logic [CNT_CFG_W-1:0] node_inputs;
      logic [CNT_CFG_W-1:0] mux_count;
   } cfg_type;

   // Result before the mean is formed.
   typedef struct packed {
      logic              accepted;
      logic              reading_valid;
      logic [CHAN_W-1:0] reading_index;
      logic [SUM_W-1:0]  sum;
      logic [SEL_W-1:0]  node_select;
      logic [SEL_W-1:0]  mux_select;
   } raw_type;

   // Zero or out-of-range counts behave as sixteen.
   function automatic logic [CNT_CFG_W-1:0] eff_count(input logic [CNT_CFG_W-1:0] v);
      logic [CNT_CFG_W-1:0] r;
      r = ((v == '0) || (v > SEL_COUNT_MAX)) ? SEL_COUNT_MAX : v;
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/amsa_req_if.sv
// Request channel carrying one raw conversion per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface amsa_req_if;
   logic                      valid;
   logic                      ready;
   logic [amsa_pkg::IN_W-1:0] adc_value;

   modport source (output valid, output adc_value, input ready);
   modport sink   (input valid, input adc_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/amsa_rsp_if.sv
// Response channel carrying one result per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface amsa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        accepted;
   logic                        reading_valid;
   logic [amsa_pkg::CHAN_W-1:0] reading_index;
   logic [amsa_pkg::ADC_W-1:0]  reading_value;
   logic [amsa_pkg::SEL_W-1:0]  node_select;
   logic [amsa_pkg::SEL_W-1:0]  mux_select;

   modport source (output valid, output accepted, output reading_valid,
                   output reading_index, output reading_value,
                   output node_select, output mux_select, input ready);
   modport sink   (input valid, input accepted, input reading_valid,
                   input reading_index, input reading_value,
                   input node_select, input mux_select, output ready);
endinterface

`default_nettype wire

### hw/rtl/amsa_front.sv
// Front stage: take conversions and classify them against the range limit.
`timescale 1ns / 1ps
`default_nettype none

module amsa_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   amsa_req_if.sink                          req_ch,
   input  wire logic [amsa_pkg::ADC_W-1:0]   adc_max,
   input  wire logic                         queue_full,
   output      logic                         push,
   output      amsa_pkg::sample_type         push_item
);
   import amsa_pkg::*;

   logic       valid_ff, valid_in;
   sample_type item_ff, item_in;
   logic       take;

   assign push         = valid_ff && !queue_full;
   assign req_ch.ready = !valid_ff || !queue_full;
   assign take         = req_ch.valid && req_ch.ready;
   assign push_item    = item_ff;

   always_comb begin
      valid_in = take ? 1'b1 : (push ? 1'b0 : valid_ff);
      item_in.accepted = (req_ch.adc_value <= {{(IN_W-ADC_W){1'b0}}, adc_max});
      item_in.value    = req_ch.adc_value[ADC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/amsa_queue.sv
// Short FIFO between the classifying front and the averaging back.
`timescale 1ns / 1ps
`default_nettype none

module amsa_queue #(
   parameter int WIDTH = 13,
   parameter int DEPTH = amsa_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic             head_valid,
   output      logic [WIDTH-1:0] head_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

endmodule

`default_nettype wire

### hw/rtl/amsa_back.sv
// Back part: accumulate samples, advance the scan, form the mean.
`timescale 1ns / 1ps
`default_nettype none

module amsa_back #(
   parameter int SAMPLES      = amsa_pkg::DEFAULT_SAMPLES,
   parameter int MAX_CHANNELS = amsa_pkg::DEFAULT_MAX_CHANNELS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire amsa_pkg::cfg_type    cfg,
   input  wire logic                 head_valid,
   input  wire amsa_pkg::sample_type head_item,
   output      logic                 pop,
   amsa_rsp_if.source                rsp_ch
);
   import amsa_pkg::*;

   localparam int    CNT_W   = $clog2(SAMPLES + 2);
   localparam int    SHIFT   = SUM_W + 4;
   localparam int    RECIP_W = SHIFT + 1;
   localparam longint RECIP_L = ((longint'(1) << SHIFT) + SAMPLES - 1) / SAMPLES;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   // scan state
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic [SEL_W-1:0]  node_ff, node_in;
   logic [SEL_W-1:0]  mux_ff, mux_in;

   // update stage and output stage
   logic    a_valid_ff, a_valid_in, a_ready;
   raw_type a_ff, a_in;
   logic    b_valid_ff, b_valid_in, b_ready;

   logic [CHAN_W-1:0]  b_index_ff;
   logic [ADC_W-1:0]   b_value_ff;
   logic               b_acc_ff, b_rvalid_ff;
   logic [SEL_W-1:0]   b_node_ff, b_mux_ff;

   logic [SUM_W-1:0]         sum_add;
   logic [CNT_W-1:0]         cnt_inc;
   logic [CNT_CFG_W-1:0]     node_nxt, mux_nxt;
   logic [CHAN_W:0]          chan_nxt;
   logic                     reading;
   logic [SUM_W+RECIP_W-1:0] product;

   assign b_ready = !b_valid_ff || rsp_ch.ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign pop     = head_valid && a_ready;

   always_comb begin
      sum_add  = sum_ff + SUM_W'(head_item.value);
      cnt_inc  = cnt_ff + 1'b1;
      node_nxt = {1'b0, node_ff} + 1'b1;
      mux_nxt  = {1'b0, mux_ff} + 1'b1;
      chan_nxt = {1'b0, chan_ff} + 1'b1;
      reading  = pop && head_item.accepted && (cnt_inc == CNT_W'(SAMPLES + 1));

      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      chan_in = chan_ff;
      node_in = node_ff;
      mux_in  = mux_ff;

      if (pop && head_item.accepted) begin
         cnt_in = cnt_inc;
         if (cnt_ff != '0) begin
            sum_in = sum_add;
         end
      end
      if (reading) begin
         sum_in  = '0;
         cnt_in  = '0;
         chan_in = (chan_nxt >= (CHAN_W+1)'(MAX_CHANNELS)) ? '0 : chan_nxt[CHAN_W-1:0];
         if (node_nxt >= eff_count(cfg.node_inputs)) begin
            node_in = '0;
            if (mux_nxt >= eff_count(cfg.mux_count)) begin
               mux_in  = '0;
               chan_in = '0;
            end else begin
               mux_in = mux_nxt[SEL_W-1:0];
            end
         end else begin
            node_in = node_nxt[SEL_W-1:0];
         end
      end

      a_in.accepted      = head_item.accepted;
      a_in.reading_valid = reading;
      a_in.reading_index = reading ? chan_ff : '0;
      a_in.sum           = reading ? sum_add : '0;
      a_in.node_select   = node_in;
      a_in.mux_select    = mux_in;

      a_valid_in = pop ? 1'b1 : (b_ready ? 1'b0 : a_valid_ff);
      b_valid_in = (a_valid_ff && b_ready) ? 1'b1 : (rsp_ch.ready ? 1'b0 : b_valid_ff);
   end

   // Mean by reciprocal multiply; exact for every 16-bit sum.
   assign product = a_ff.sum * RECIP;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         cnt_ff     <= '0;
         chan_ff    <= '0;
         node_ff    <= '0;
         mux_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         sum_ff     <= sum_in;
         cnt_ff     <= cnt_in;
         chan_ff    <= chan_in;
         node_ff    <= node_in;
         mux_ff     <= mux_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      if (pop) begin
         a_ff <= a_in;
      end
      if (a_valid_ff && b_ready) begin
         b_acc_ff    <= a_ff.accepted;
         b_rvalid_ff <= a_ff.reading_valid;
         b_index_ff  <= a_ff.reading_index;
         b_value_ff  <= product[SHIFT +: ADC_W];
         b_node_ff   <= a_ff.node_select;
         b_mux_ff    <= a_ff.mux_select;
      end
   end

   assign rsp_ch.valid         = b_valid_ff;
   assign rsp_ch.accepted      = b_acc_ff;
   assign rsp_ch.reading_valid = b_rvalid_ff;
   assign rsp_ch.reading_index = b_index_ff;
   assign rsp_ch.reading_value = b_value_ff;
   assign rsp_ch.node_select   = b_node_ff;
   assign rsp_ch.mux_select    = b_mux_ff;

   a_reading_needs_sample: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |-> (!a_ff.reading_valid || a_ff.accepted))
      else $error("reading completed by a rejected sample");
   a_quiet_when_no_reading: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !a_ff.reading_valid) |-> (a_ff.reading_index == '0 && a_ff.sum == '0))
      else $error("reading payload not cleared");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SAMPLES))
      else $error("sample counter ran past its limit");
   a_scan_frozen_on_reject: assert property (@(posedge clock) disable iff (reset)
      (pop && !head_item.accepted) |=> ($stable(node_ff) && $stable(mux_ff) && $stable(cnt_ff)))
      else $error("rejected sample moved the scan");

endmodule

`default_nettype wire

### hw/rtl/adc_mux_scan_averager_core.sv
// Top level of the ADC mux scan averager: setup registers, front, queue, back.
// A result reaches rsp through the front register, the queue, the update stage and the
// mean/output stage, in that order.
// Throughput: one transfer per cycle sustained while rsp is ready; the per-channel state
// update in the back stage is combinational, and the two-entry queue buffers rsp stalls.
// Reset (synchronous, active high): empties all stages, zeroes sum, counter, channel
// and selects, loads node_inputs=16, mux_count=2, adc_max=4095.
`timescale 1ns / 1ps
`default_nettype none

module adc_mux_scan_averager_core #(
   parameter int SAMPLES      = amsa_pkg::DEFAULT_SAMPLES,
   parameter int MAX_CHANNELS = amsa_pkg::DEFAULT_MAX_CHANNELS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   amsa_req_if.sink                               req_ch,
   amsa_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [amsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [amsa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import amsa_pkg::*;

   // setup registers
   logic [CNT_CFG_W-1:0] node_inputs_ff, node_inputs_in;
   logic [CNT_CFG_W-1:0] mux_count_ff, mux_count_in;
   logic [ADC_W-1:0]     adc_max_ff, adc_max_in;
   cfg_type              cfg;

   // front to queue to back
   logic       push, queue_full, pop, head_valid;
   sample_type push_item, head_item;

   // Decode setup writes; an index past the list is dropped.
   always_comb begin
      node_inputs_in = node_inputs_ff;
      mux_count_in   = mux_count_ff;
      adc_max_in     = adc_max_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_INPUTS: node_inputs_in = csr_wdata[CNT_CFG_W-1:0];
            CSR_MUX_COUNT:   mux_count_in   = csr_wdata[CNT_CFG_W-1:0];
            CSR_ADC_MAX:     adc_max_in     = csr_wdata[ADC_W-1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_inputs_ff <= NODE_INPUTS_RESET;
         mux_count_ff   <= MUX_COUNT_RESET;
         adc_max_ff     <= ADC_MAX_RESET;
      end else begin
         node_inputs_ff <= node_inputs_in;
         mux_count_ff   <= mux_count_in;
         adc_max_ff     <= adc_max_in;
      end
   end

   assign cfg.node_inputs = node_inputs_ff;
   assign cfg.mux_count   = mux_count_ff;

   // Front: register each transfer and tag it in or out of range.
   amsa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .adc_max    (adc_max_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // Queue: decouple the front from rsp back-pressure.
   amsa_queue #(
      .WIDTH ($bits(sample_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_item)
   );

   // Back: accumulate, advance the scan, divide and hold the result.
   amsa_back #(
      .SAMPLES      (SAMPLES),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

   a_push_follows_front: assert property (@(posedge clock) disable iff (reset)
      (push && pop) |-> head_valid)
      else $error("queue pop without a head entry");
   a_setup_held_without_write: assert property (@(posedge clock) disable iff (reset)
      !csr_we |=> ($stable(adc_max_ff) && $stable(node_inputs_ff) && $stable(mux_count_ff)))
      else $error("setup register changed without a write");
   a_rsp_valid_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result offered right after reset");

endmodule

`default_nettype wire

### dv/adc_mux_scan_averager_core_tb.sv
// Self-checking testbench for the ADC mux scan averager core.
`timescale 1ns / 1ps

module adc_mux_scan_averager_core_tb;
   import amsa_pkg::*;

   localparam int SCAN_SAMPLES  = DEFAULT_SAMPLES;
   localparam int SCAN_CHANNELS = DEFAULT_MAX_CHANNELS;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int HOLD_CYCLES   = 300;   // long receiver stall, fills the pipe
   localparam int HOLD_AT       = 400;   // result count at which that stall starts
   localparam int PHASES        = 7;
   // Index 3 decodes to no register; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic              accepted;
      logic              reading_valid;
      logic [CHAN_W-1:0] reading_index;
      logic [ADC_W-1:0]  reading_value;
      logic [SEL_W-1:0]  node_select;
      logic [SEL_W-1:0]  mux_select;
   } scan_result_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] csr;    // register index, CSR rows only
      logic [IN_W-1:0]      data;   // conversion, or write data in the low bits
      bit                   typed;  // expected result given in the row
      scan_result_type      want;
   } dir_row_type;

   localparam int DIR_ROWS = 33;

   // Directed part. Rows with typed results are read straight off the spec;
   // the rest go through the predictor.
   dir_row_type dir_rows [DIR_ROWS] = '{
      // after reset: first sample settles, out-of-range values are dropped
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd0,     1'b1, {1'b1, 1'b0, 8'd0, 12'd0, 4'd0, 4'd0}},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4096,  1'b1, {1'b0, 1'b0, 8'd0, 12'd0, 4'd0, 4'd0}},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'hFFFF,  1'b1, {1'b0, 1'b0, 8'd0, 12'd0, 4'd0, 4'd0}},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4095,  1'b1, {1'b1, 1'b0, 8'd0, 12'd0, 4'd0, 4'd0}},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4095,  1'b1, {1'b1, 1'b0, 8'd0, 12'd0, 4'd0, 4'd0}},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4095,  1'b1, {1'b1, 1'b0, 8'd0, 12'd0, 4'd0, 4'd0}},
      // full-scale reading on channel 0, node select moves to 1
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4095,  1'b1, {1'b1, 1'b1, 8'd0, 12'd4095, 4'd1, 4'd0}},
      // lower the node count so the live node select lies outside it
      '{ROW_CSR,    CSR_NODE_INPUTS, 16'd1,     1'b0, '0},
      '{ROW_CSR,    CSR_MUX_COUNT,   16'd16,    1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4,     1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd1,     1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd2,     1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd3,     1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd3,     1'b0, '0},
      // tightest range: only zero passes
      '{ROW_CSR,    CSR_ADC_MAX,     16'd0,     1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd0,     1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd1,     1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'h8000,  1'b0, '0},
      // zero and oversize counts behave as sixteen; upper data bits drop
      '{ROW_CSR,    CSR_ADC_MAX,     16'h0FFF,  1'b0, '0},
      '{ROW_CSR,    CSR_NODE_INPUTS, 16'h0FE0,  1'b0, '0},
      '{ROW_CSR,    CSR_MUX_COUNT,   16'h003F,  1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd100,   1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4095,  1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd0,     1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4095,  1'b0, '0},
      '{ROW_CSR,    CSR_SPARE,       16'h0ABC,  1'b0, '0},
      // one input, one mux: the next reading wraps everything back to zero
      '{ROW_CSR,    CSR_NODE_INPUTS, 16'd1,     1'b0, '0},
      '{ROW_CSR,    CSR_MUX_COUNT,   16'd1,     1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd7,     1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4095,  1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4095,  1'b0, '0},
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4095,  1'b0, '0},
      // mean of 16379 truncates to 4094
      '{ROW_SAMPLE, CSR_NODE_INPUTS, 16'd4094,  1'b0, '0}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   amsa_req_if req_bus ();
   amsa_rsp_if rsp_bus ();

   adc_mux_scan_averager_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the block: setup registers and scan state.
   logic [CNT_CFG_W-1:0] cfg_nodes;
   logic [CNT_CFG_W-1:0] cfg_muxes;
   logic [ADC_W-1:0]     cfg_adc_max;
   logic [SUM_W-1:0]     acc_sum;
   logic [4:0]           acc_count;
   logic [CHAN_W-1:0]    chan_idx;
   logic [SEL_W-1:0]     node_sel;
   logic [SEL_W-1:0]     mux_sel;

   scan_result_type pending_results [$];
   int              mismatches;
   int              items_sent;
   int              cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Zero or oversize counts scan all sixteen positions.
   function automatic int scan_length(input logic [CNT_CFG_W-1:0] v);
      return (v == 0 || v > 16) ? 16 : int'(v);
   endfunction

   function automatic void apply_setup(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_NODE_INPUTS: cfg_nodes   = data[CNT_CFG_W-1:0];
         CSR_MUX_COUNT:   cfg_muxes   = data[CNT_CFG_W-1:0];
         CSR_ADC_MAX:     cfg_adc_max = data[ADC_W-1:0];
         default: ;
      endcase
   endfunction

   // Advance the shadow by one conversion and return the result it causes.
   function automatic scan_result_type step_scan(input logic [IN_W-1:0] v);
      scan_result_type r;
      logic [SUM_W-1:0] mean;
      int               next_chan;
      int               next_node;
      int               next_mux;
      r = '0;
      if (v <= {4'b0, cfg_adc_max}) begin
         r.accepted = 1'b1;
         // the first sample of a channel only lets the input settle
         if (acc_count != 0)
            acc_sum = acc_sum + v;
         acc_count = acc_count + 5'd1;
         if (acc_count >= SCAN_SAMPLES + 1) begin
            mean            = acc_sum / SCAN_SAMPLES;
            r.reading_valid = 1'b1;
            r.reading_index = chan_idx;
            r.reading_value = mean[ADC_W-1:0];
            acc_sum         = '0;
            acc_count       = '0;
            next_chan       = int'(chan_idx) + 1;
            chan_idx        = (next_chan >= SCAN_CHANNELS) ? '0 : CHAN_W'(next_chan);
            next_node       = int'(node_sel) + 1;
            if (next_node >= scan_length(cfg_nodes)) begin
               node_sel = '0;
               next_mux = int'(mux_sel) + 1;
               if (next_mux >= scan_length(cfg_muxes)) begin
                  mux_sel  = '0;
                  chan_idx = '0;
               end else begin
                  mux_sel = SEL_W'(next_mux);
               end
            end else begin
               node_sel = SEL_W'(next_node);
            end
         end
      end
      r.node_select = node_sel;
      r.mux_select  = mux_sel;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t MISMATCH %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
   endtask

   // Write one setup register; the write lands at the next edge.
   task automatic write_setup(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_setup(idx, data);
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Offer one conversion after a random gap and hold it until the transfer.
   task automatic send_sample(input logic [IN_W-1:0] v, input bit typed,
                              input scan_result_type want);
      scan_result_type predicted;
      int              gap;
      bit              steady;
      steady = (items_sent % 40 < 10);   // stretches with no idling
      gap    = steady ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.adc_value <= v;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      // transfer done: predict, and push the typed result where one is given
      predicted = step_scan(v);
      pending_results.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Encode a count register write with random bits above the count field.
   function automatic logic [CSR_DATA_W-1:0] count_word(input int count);
      logic [CSR_DATA_W-1:0] w;
      w = CSR_DATA_W'($urandom_range(0, 4095));
      w[CNT_CFG_W-1:0] = CNT_CFG_W'(count);
      return w;
   endfunction

   // Stimulus: reset, directed table, then random phases between setup writes.
   initial begin : stimulus
      int                nodes;
      int                muxes;
      int                amax;
      int                count;
      int                keep_pct;
      logic [IN_W-1:0]   v;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_NODE_INPUTS;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.adc_value <= '0;
      mismatches  = 0;
      items_sent  = 0;
      cfg_nodes   = NODE_INPUTS_RESET;
      cfg_muxes   = MUX_COUNT_RESET;
      cfg_adc_max = ADC_MAX_RESET;
      acc_sum     = '0;
      acc_count   = '0;
      chan_idx    = '0;
      node_sel    = '0;
      mux_sel     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; drain before every register write.
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            quiesce();
            write_setup(dir_rows[i].csr, dir_rows[i].data[CSR_DATA_W-1:0]);
         end else begin
            send_sample(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // Random phases. The first runs the widest scan long enough to pass
      // channel 255 and the full wrap; the rest sweep other settings, and
      // each one may leave the selects beyond the next phase's counts.
      for (int p = 0; p < PHASES; p++) begin
         quiesce();
         case (p)
            0: begin nodes = 16; muxes = 16; amax = 4095; end
            1: begin nodes = 1;  muxes = 1;  amax = 0;    end
            2: begin nodes = 16; muxes = 1;  amax = $urandom_range(0, 4095); end
            default: begin
               nodes = $urandom_range(0, 31);
               muxes = $urandom_range(0, 31);
               amax  = $urandom_range(0, 4095);
            end
         endcase
         write_setup(CSR_NODE_INPUTS, count_word(nodes));
         write_setup(CSR_MUX_COUNT, count_word(muxes));
         write_setup(CSR_ADC_MAX, CSR_DATA_W'(amax));
         if (p == 3)
            write_setup(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 4095)));
         count    = (p == 0) ? 1400 : 92;
         keep_pct = (p == 0) ? 98 : 85;
         for (int i = 0; i < count; i++) begin
            // mostly in-range conversions that build readings, some noise
            if ($urandom_range(0, 99) < keep_pct)
               v = IN_W'($urandom_range(0, amax));
            else
               v = IN_W'($urandom_range(amax + 1, 65535));
            send_sample(v, 1'b0, '0);
         end
      end

      quiesce();
      repeat (12) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: random stalls, one long hold-off, check every transfer.
   initial begin : result_side
      scan_result_type got;
      scan_result_type want;
      int              stall;
      int              seen;
      seen = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         stall = (seen % 50 < 12) ? 0 : $urandom_range(0, 19);
         // hold off long enough to back up into the request side
         if (seen == HOLD_AT)
            stall = HOLD_CYCLES;
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid)
            @(posedge clock);
         got = {rsp_bus.accepted, rsp_bus.reading_valid, rsp_bus.reading_index,
                rsp_bus.reading_value, rsp_bus.node_select, rsp_bus.mux_select};
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing pending");
         end else begin
            want = pending_results.pop_front();
            check_field("accepted", got.accepted, want.accepted);
            check_field("reading_valid", got.reading_valid, want.reading_valid);
            check_field("reading_index", got.reading_index, want.reading_index);
            check_field("reading_value", got.reading_value, want.reading_value);
            check_field("node_select", got.node_select, want.node_select);
            check_field("mux_select", got.mux_select, want.mux_select);
         end
         seen++;
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
hw/rtl/amsa_pkg.sv
hw/rtl/amsa_req_if.sv
hw/rtl/amsa_rsp_if.sv
hw/rtl/amsa_front.sv
hw/rtl/amsa_queue.sv
hw/rtl/amsa_back.sv
hw/rtl/adc_mux_scan_averager_core.sv
dv/adc_mux_scan_averager_core_tb.sv
